// ===== sv/fcw_pkg.sv =====
`timescale 1ns / 1ps

package fcw_pkg;

   // Table geometry
   localparam int TABLE_BYTES  = 8192;
   localparam int SECTOR_BYTES = 512;
   localparam int BANK_DEPTH   = TABLE_BYTES / 2;
   localparam int BANK_AW      = $clog2(BANK_DEPTH);

   // Field widths
   localparam int CMD_W        = 1;
   localparam int ADDR_W       = 13;
   localparam int BYTE_W       = 8;
   localparam int CLUSTER_W    = 12;
   localparam int OFFSET_W     = 21;
   localparam int SECTOR_W     = 16;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int STEP_W       = OFFSET_W - SECTOR_SHIFT;
   localparam int BASE_W       = CLUSTER_W + 2;
   localparam int RANGE_W      = $clog2(TABLE_BYTES) + 2;

   // Cluster code limits
   localparam logic [CLUSTER_W-1:0] CLUSTER_FIRST = CLUSTER_W'(2);
   localparam logic [CLUSTER_W-1:0] CLUSTER_LIMIT = CLUSTER_W'(12'hFF0);

   // Request commands
   localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // Table write request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } table_wr_type;

   // Entry returned by the table in the cycle after its cluster is presented
   typedef struct packed {
      logic [CLUSTER_W-1:0] entry;
      logic                 in_range;
   } table_rd_type;

   function automatic logic cluster_usable(input logic [CLUSTER_W-1:0] c);
      return (c >= CLUSTER_FIRST) && (c < CLUSTER_LIMIT);
   endfunction

endpackage

// ===== sv/fcw_if.sv =====
`timescale 1ns / 1ps

// Request channel: table byte writes and sector lookups
interface fcw_req_if;
   logic                               valid;
   logic                               ready;
   logic [fcw_pkg::CMD_W-1:0]          cmd;
   logic [fcw_pkg::ADDR_W-1:0]         table_address;
   logic [fcw_pkg::BYTE_W-1:0]         table_byte;
   logic [fcw_pkg::CLUSTER_W-1:0]      start_cluster;
   logic [fcw_pkg::OFFSET_W-1:0]       byte_offset;

   modport source (output valid, cmd, table_address, table_byte, start_cluster, byte_offset,
                   input ready);
   modport sink   (input valid, cmd, table_address, table_byte, start_cluster, byte_offset,
                   output ready);
endinterface

// Response channel: one per lookup
interface fcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fcw_pkg::SECTOR_W-1:0]  sector;
   logic                          chain_error;

   modport source (output valid, sector, chain_error, input ready);
   modport sink   (input valid, sector, chain_error, output ready);
endinterface

// ===== sv/fcw_table.sv =====
`timescale 1ns / 1ps

// Allocation table in two byte banks (even and odd addresses), so the two
// bytes of any 12-bit entry come out together from one registered read.
module fcw_table (
   input  logic                          clock,
   input  fcw_pkg::table_wr_type         wr,
   input  logic [fcw_pkg::CLUSTER_W-1:0] rd_cluster,
   output fcw_pkg::table_rd_type         rd
);

   logic [fcw_pkg::BYTE_W-1:0] bank0_mem [fcw_pkg::BANK_DEPTH];
   logic [fcw_pkg::BYTE_W-1:0] bank1_mem [fcw_pkg::BANK_DEPTH];

   logic [fcw_pkg::BYTE_W-1:0]  bank0_q_ff;
   logic [fcw_pkg::BYTE_W-1:0]  bank1_q_ff;
   logic                        lo_bank_ff;
   logic                        odd_ff;
   logic                        in_range_ff;

   logic [fcw_pkg::BASE_W-1:0]  base;
   logic [fcw_pkg::BASE_W-1:0]  lo_addr;
   logic [fcw_pkg::BASE_W-1:0]  half_addr;
   logic [fcw_pkg::BANK_AW-1:0] bank0_idx;
   logic [fcw_pkg::BANK_AW-1:0] bank1_idx;
   logic                        in_range;
   logic [fcw_pkg::BYTE_W-1:0]  lo_byte;
   logic [fcw_pkg::BYTE_W-1:0]  hi_byte;

   // Locate the byte pair: three bytes per two entries, odd entries start one later
   always_comb begin
      base      = (fcw_pkg::BASE_W'(rd_cluster[fcw_pkg::CLUSTER_W-1:1]) << 1)
                + fcw_pkg::BASE_W'(rd_cluster[fcw_pkg::CLUSTER_W-1:1]);
      lo_addr   = base + fcw_pkg::BASE_W'(rd_cluster[0]);
      half_addr = lo_addr >> 1;
      in_range  = (fcw_pkg::RANGE_W'(base) + fcw_pkg::RANGE_W'(2))
                < fcw_pkg::RANGE_W'(fcw_pkg::TABLE_BYTES);
      bank1_idx = half_addr[fcw_pkg::BANK_AW-1:0];
      if (lo_addr[0]) begin
         bank0_idx = half_addr[fcw_pkg::BANK_AW-1:0] + fcw_pkg::BANK_AW'(1);
      end else begin
         bank0_idx = half_addr[fcw_pkg::BANK_AW-1:0];
      end
   end

   // Write one byte into its bank
   always_ff @(posedge clock) begin
      if (wr.en && !wr.addr[0]) begin
         bank0_mem[wr.addr[fcw_pkg::ADDR_W-1:1]] <= wr.data;
      end
      if (wr.en && wr.addr[0]) begin
         bank1_mem[wr.addr[fcw_pkg::ADDR_W-1:1]] <= wr.data;
      end
   end

   // Read both banks, register the unpack selects alongside
   always_ff @(posedge clock) begin
      bank0_q_ff  <= bank0_mem[bank0_idx];
      bank1_q_ff  <= bank1_mem[bank1_idx];
      lo_bank_ff  <= lo_addr[0];
      odd_ff      <= rd_cluster[0];
      in_range_ff <= in_range;
   end

   // Unpack the 12-bit entry from the byte pair
   always_comb begin
      lo_byte = lo_bank_ff ? bank1_q_ff : bank0_q_ff;
      hi_byte = lo_bank_ff ? bank0_q_ff : bank1_q_ff;
      if (odd_ff) begin
         rd.entry = {hi_byte, lo_byte[7:4]};
      end else begin
         rd.entry = {hi_byte[3:0], lo_byte};
      end
      rd.in_range = in_range_ff;
   end

endmodule

// ===== sv/fat12_cluster_chain_walker.sv =====
`timescale 1ns / 1ps
// Table write: taken with no response; another request may follow at once.
// Lookup: walks floor(byte_offset/512) links from start_cluster, then registers the response; one
// link per cycle set by the table's registered read; a bad cluster ends the walk early.
// One lookup at a time: the next request is taken only once the walk and ST_DONE are through,
// and is held off while a finished response still waits in the output register.
// Reset (synchronous) clears control state and sets data_start_sector to 33; table undefined.
module fat12_cluster_chain_walker (
   input  logic                         clock,
   input  logic                         reset,
   fcw_req_if.sink                      req_chan,
   fcw_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [fcw_pkg::SECTOR_W-1:0] csr_wr_data
);

   fcw_pkg::state_type state_ff, state_in;

   logic [fcw_pkg::SECTOR_W-1:0]  dss_ff;
   logic [fcw_pkg::CLUSTER_W-1:0] clus_ff, clus_in;
   logic [fcw_pkg::STEP_W-1:0]    steps_ff, steps_in;
   logic [fcw_pkg::SECTOR_W-1:0]  res_sector_ff, res_sector_in;
   logic                          res_err_ff, res_err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fcw_pkg::SECTOR_W-1:0]  rsp_sector_ff, rsp_sector_in;
   logic                          rsp_err_ff, rsp_err_in;

   logic                          req_fire;
   logic [fcw_pkg::STEP_W-1:0]    req_steps;
   logic [fcw_pkg::CLUSTER_W-1:0] rd_cluster;
   fcw_pkg::table_wr_type         tbl_wr;
   fcw_pkg::table_rd_type         tbl_rd;

   function automatic logic [fcw_pkg::SECTOR_W-1:0] to_sector(
      input logic [fcw_pkg::CLUSTER_W-1:0] c,
      input logic [fcw_pkg::SECTOR_W-1:0]  dss);
      return fcw_pkg::SECTOR_W'(c) + dss - fcw_pkg::SECTOR_W'(2);
   endfunction

   fcw_table u_table (
      .clock      (clock),
      .wr         (tbl_wr),
      .rd_cluster (rd_cluster),
      .rd         (tbl_rd)
   );

   assign req_chan.ready       = (state_ff == fcw_pkg::ST_IDLE);
   assign req_fire             = req_chan.valid && req_chan.ready;
   assign req_steps            = req_chan.byte_offset[fcw_pkg::OFFSET_W-1:fcw_pkg::SECTOR_SHIFT];
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sector      = rsp_sector_ff;
   assign rsp_chan.chain_error = rsp_err_ff;

   // Route table byte writes straight from the request
   always_comb begin
      tbl_wr.en   = req_fire && (req_chan.cmd == fcw_pkg::CMD_WRITE)
                 && (32'(req_chan.table_address) < fcw_pkg::TABLE_BYTES);
      tbl_wr.addr = req_chan.table_address;
      tbl_wr.data = req_chan.table_byte;
   end

   // Next state and walk datapath
   always_comb begin
      state_in      = state_ff;
      clus_in       = clus_ff;
      steps_in      = steps_ff;
      res_sector_in = res_sector_ff;
      res_err_in    = res_err_ff;
      rd_cluster    = clus_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_sector_in = rsp_sector_ff;
      rsp_err_in    = rsp_err_ff;

      unique case (state_ff)
         fcw_pkg::ST_IDLE: begin
            rd_cluster = req_chan.start_cluster;
            if (req_fire && (req_chan.cmd == fcw_pkg::CMD_LOOKUP)) begin
               clus_in       = req_chan.start_cluster;
               steps_in      = req_steps;
               res_sector_in = to_sector(req_chan.start_cluster, dss_ff);
               res_err_in    = 1'b0;
               if (!fcw_pkg::cluster_usable(req_chan.start_cluster)) begin
                  res_sector_in = '0;
                  res_err_in    = 1'b1;
                  state_in      = fcw_pkg::ST_DONE;
               end else if (req_steps == '0) begin
                  state_in = fcw_pkg::ST_DONE;
               end else begin
                  state_in = fcw_pkg::ST_WALK;
               end
            end
         end
         fcw_pkg::ST_WALK: begin
            // Follow one link; read the next entry in the same cycle
            rd_cluster = tbl_rd.entry;
            if (!tbl_rd.in_range || !fcw_pkg::cluster_usable(tbl_rd.entry)) begin
               res_sector_in = '0;
               res_err_in    = 1'b1;
               state_in      = fcw_pkg::ST_DONE;
            end else begin
               clus_in       = tbl_rd.entry;
               steps_in      = steps_ff - fcw_pkg::STEP_W'(1);
               res_sector_in = to_sector(tbl_rd.entry, dss_ff);
               res_err_in    = 1'b0;
               if (steps_ff == fcw_pkg::STEP_W'(1)) begin
                  state_in = fcw_pkg::ST_DONE;
               end
            end
         end
         fcw_pkg::ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sector_in = res_sector_ff;
               rsp_err_in    = res_err_ff;
               state_in      = fcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcw_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dss_ff       <= fcw_pkg::SECTOR_W'(33);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dss_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      clus_ff       <= clus_in;
      steps_ff      <= steps_in;
      res_sector_ff <= res_sector_in;
      res_err_ff    <= res_err_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_err_ff    <= rsp_err_in;
   end

`ifndef ASSERT_OFF
   a_err_zero_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_sector_ff == '0)
      else $error("chain error response with nonzero sector");

   a_walk_steps_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcw_pkg::ST_WALK |-> steps_ff != '0)
      else $error("walking with no links left");

   a_walk_usable: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcw_pkg::ST_WALK |-> fcw_pkg::cluster_usable(clus_ff))
      else $error("walking from an unusable cluster");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> state_ff == fcw_pkg::ST_IDLE)
      else $error("table write outside idle");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcw_pkg::ST_DONE && rsp_valid_ff && !rsp_chan.ready
      |=> state_ff == fcw_pkg::ST_DONE && rsp_valid_ff)
      else $error("response dropped while output register busy");
`endif

endmodule
